// ----- src/pol_pkg.sv -----
`default_nettype none

package pol_pkg;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_POS   = 3'd1,
    MODE_INS_END   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_POS   = 3'd4,
    MODE_DEL_END   = 3'd5,
    MODE_READ_OUT  = 3'd6,
    MODE_NONE      = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_WR,
    S_DEL,
    S_DEL_WR,
    S_OUT_RD,
    S_OUT_EM
  } state_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 5;

endpackage

`default_nettype wire

// ----- src/positional_ordered_list.sv -----
// One request at a time; busy_o is high while the sequencer walks the store. An error result
// is registered from the idle decode; an insert or delete without shifting first passes
// S_INS or S_DEL. Each entry an insert or delete moves takes a read state and a write state
// in the single-port store; read-out reads each element in S_OUT_RD and shows it in S_OUT_EM.
// Reset: rst_ni (async, active low) empties the list; store contents are left as they are.
// Results are strobed by valid_o for one cycle; the receiver cannot stall.
`default_nettype none

module positional_ordered_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [2:0]                        mode_i,
  input  wire logic signed [pol_pkg::DataW-1:0]  value_i,
  input  wire logic [pol_pkg::PosW-1:0]          position_i,
  output logic                                   valid_o,
  output logic [1:0]                             status_o,
  output logic signed [pol_pkg::DataW-1:0]       element_o,
  output logic [pol_pkg::CountW-1:0]             count_o,
  output logic                                   last_o
);
  import pol_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      ptr_q, ptr_d;
  logic [IdxW-1:0]      tgt_q, tgt_d;
  logic [DataW-1:0]     val_q, val_d;

  logic                 res_valid_q, res_valid_d;
  status_e              res_status_q, res_status_d;
  logic [DataW-1:0]     res_elem_q, res_elem_d;
  logic                 res_last_q, res_last_d;

  logic [DataW-1:0]     mem_q [CAPACITY];
  logic [DataW-1:0]     rd_q;
  logic                 rd_en, wr_en;
  logic [IdxW-1:0]      rd_addr, wr_addr;
  logic [DataW-1:0]     wr_data;

  logic                 accept;
  logic                 is_full, is_empty;
  logic                 ins_go, del_go, out_go;
  logic                 at_tgt, at_end;
  logic [CmpW-1:0]      pos_ext, cnt_ext;
  logic [CntW-1:0]      ptr_next_ext;
  logic [CntW+CountW-1:0] cnt_wide;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign is_full  = (cnt_q == CntW'(CAPACITY));
  assign is_empty = (cnt_q == '0);
  assign pos_ext  = CmpW'(position_i);
  assign cnt_ext  = CmpW'(cnt_q);
  assign ptr_next_ext = CntW'(ptr_q) + CntW'(1);
  assign at_tgt   = (ptr_q == tgt_q);
  assign at_end   = (ptr_next_ext == cnt_q);

  // decode of the request in idle
  always_comb begin
    ins_go = 1'b0;
    del_go = 1'b0;
    out_go = 1'b0;
    case (mode_i)
      MODE_INS_FRONT, MODE_INS_END: begin
        ins_go = accept && !is_full;
      end
      MODE_INS_POS: begin
        ins_go = accept && !is_full && (is_empty || (pos_ext <= cnt_ext));
      end
      MODE_DEL_FRONT, MODE_DEL_END: begin
        del_go = accept && !is_empty;
      end
      MODE_DEL_POS: begin
        del_go = accept && !is_empty && (pos_ext < cnt_ext);
      end
      MODE_READ_OUT: begin
        out_go = accept && !is_empty;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (ins_go) begin
          state_d = S_INS;
        end else if (del_go) begin
          state_d = S_DEL;
        end else if (out_go) begin
          state_d = S_OUT_RD;
        end
      end
      S_INS:    state_d = at_tgt ? S_IDLE : S_INS_WR;
      S_INS_WR: state_d = S_INS;
      S_DEL:    state_d = at_end ? S_IDLE : S_DEL_WR;
      S_DEL_WR: state_d = S_DEL;
      S_OUT_RD: state_d = S_OUT_EM;
      S_OUT_EM: state_d = at_end ? S_IDLE : S_OUT_RD;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    tgt_d        = tgt_q;
    val_d        = val_q;
    res_valid_d  = 1'b0;
    res_status_d = ST_OK;
    res_elem_d   = '0;
    res_last_d   = 1'b1;
    rd_en        = 1'b0;
    rd_addr      = ptr_q;
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_data      = rd_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = value_i;
          case (mode_i)
            MODE_INS_FRONT, MODE_INS_POS, MODE_INS_END: begin
              ptr_d = IdxW'(cnt_q);
              if (mode_i == MODE_INS_END) begin
                tgt_d = IdxW'(cnt_q);
              end else if (mode_i == MODE_INS_POS && !is_empty) begin
                tgt_d = IdxW'(position_i);
              end else begin
                tgt_d = '0;
              end
              if (is_full) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
              end else if (!ins_go) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_BOUNDS;
              end
            end
            MODE_DEL_FRONT, MODE_DEL_POS, MODE_DEL_END: begin
              if (mode_i == MODE_DEL_END) begin
                ptr_d = IdxW'(cnt_q - CntW'(1));
              end else if (mode_i == MODE_DEL_POS) begin
                ptr_d = IdxW'(position_i);
              end else begin
                ptr_d = '0;
              end
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else if (!del_go) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_BOUNDS;
              end
            end
            MODE_READ_OUT: begin
              ptr_d = '0;
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        if (at_tgt) begin
          wr_en       = 1'b1;
          wr_data     = val_q;
          cnt_d       = cnt_q + CntW'(1);
          res_valid_d = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q - IdxW'(1);
        end
      end
      S_INS_WR: begin
        // shift one entry towards the back
        wr_en = 1'b1;
        ptr_d = ptr_q - IdxW'(1);
      end
      S_DEL: begin
        if (at_end) begin
          cnt_d       = cnt_q - CntW'(1);
          res_valid_d = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q + IdxW'(1);
        end
      end
      S_DEL_WR: begin
        // close the gap by one place
        wr_en = 1'b1;
        ptr_d = ptr_q + IdxW'(1);
      end
      S_OUT_RD: begin
        rd_en = 1'b1;
      end
      S_OUT_EM: begin
        res_valid_d = 1'b1;
        res_elem_d  = rd_q;
        res_last_d  = at_end;
        ptr_d       = ptr_q + IdxW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    tgt_q        <= tgt_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_elem_q   <= res_elem_d;
    res_last_q   <= res_last_d;
  end

  // single-port list store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign cnt_wide  = {{CountW{1'b0}}, cnt_q};
  assign valid_o   = res_valid_q;
  assign status_o  = res_status_q;
  assign element_o = res_elem_q;
  assign count_o   = cnt_wide[CountW-1:0];
  assign last_o    = res_last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_ins_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS || state_q == S_INS_WR) |-> !is_full)
    else $error("insert in progress on a full list");

  a_del_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL || state_q == S_DEL_WR) |-> !is_empty)
    else $error("delete in progress on an empty list");

  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> last_o)
    else $error("error result not marked last");

  a_stream_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (busy_o && !$past(valid_o)))
    else $error("read-out transfer outside sequencer walk");

endmodule

`default_nettype wire
